[src/isa_pkg.sv]
package isa_pkg;

	localparam int QONE = 65536;

	// ceil(2^34 / 3): x * RECIP3 >> (k + 4) is floor(x * 2^(30-k) / 3) for x < 3 * 2^(k+1)
	localparam logic [32:0] RECIP3 = 33'd5726623062;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_TOOFEW = 2'd1,
		ST_UNDEF  = 2'd2
	} status_t;

	typedef enum logic {
		FUNC_VISIT  = 1'b0,
		FUNC_FINISH = 1'b1
	} func_t;

	typedef struct packed {
		logic capture;
		logic visit_upd;
		logic clr_step;
		logic fin_setup;
		logic div_start;
		logic m_load;
		logic sq_mul;
		logic sq_upd;
		logic num_mul;
		logic num_fix;
		logic score_set;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic special;
		logic div_done;
		logic out_full;
	} stat_t;

endpackage

[src/isa_ram.sv]
module isa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/isa_div.sv]
module isa_div #(
	parameter int DVD_W = 33,
	parameter int DVS_W = 30
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CW = $clog2(DVD_W + 1);

	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   rem_sh;
	logic             qbit;

	always_comb begin
		rem_sh = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
		qbit   = (rem_sh >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			quo_q <= {quo_q[DVD_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[src/isa_datapath.sv]
module isa_datapath #(
	parameter int MAX_LINES  = 4096,
	parameter int DEPTH_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [39:0]     s_tdata,
	input  isa_pkg::cmd_t   cmd,
	output isa_pkg::stat_t  st,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [79:0]     m_tdata,
	output logic [1:0]      m_tuser
);

	localparam int AW  = $clog2(MAX_LINES);
	localparam int SW  = DEPTH_BITS + 13;
	localparam int DW  = SW + 1;
	localparam int QW  = 33;
	localparam int DIN = (DEPTH_BITS < 16) ? DEPTH_BITS : 16;

	logic [11:0]           org_q;
	logic [11:0]           tgt_q;
	logic [DIN-1:0]        dep_q;
	logic [12:0]           cnt_q;
	logic [SW-1:0]         sum_q;
	logic [AW-1:0]         clr_q;
	logic                  mark;
	logic                  vis_ok;
	logic                  we;
	logic [AW-1:0]         waddr;

	logic [12:0]           n_w;
	logic [13:0]           x_w;
	logic [3:0]            k_w;
	logic signed [DW-1:0]  den_w;
	logic [12:0]           n_q;
	logic [3:0]            k_q;
	logic [46:0]           mant_prod_q;
	logic signed [DW-1:0]  den_q;
	logic                  special_q;
	logic [15:0]           frac_q;
	logic [30:0]           m_q;
	logic [61:0]           prod_q;
	logic [31:0]           sq_t;
	logic signed [20:0]    lm1;
	logic signed [34:0]    prod2_q;
	logic signed [35:0]    num_q;
	logic [QW-1:0]         nmag;
	logic [DW-1:0]         dmag;
	logic                  neg;
	logic [QW-1:0]         quo;
	logic                  div_done;
	logic signed [34:0]    qs;

	logic                  ov_q;
	logic [12:0]           on_q;
	logic [27:0]           otd_q;
	logic [31:0]           osc_q;
	isa_pkg::status_t      ost_q;
	logic [31:0]           score_q;
	isa_pkg::status_t      status_q;

	assign we    = cmd.clr_step | (cmd.visit_upd & vis_ok);
	assign waddr = cmd.clr_step ? clr_q : AW'(tgt_q);

	isa_ram #(.WIDTH(1), .DEPTH(MAX_LINES)) u_marks (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (~cmd.clr_step),
		.raddr (AW'(s_tdata[23:12])),
		.rdata (mark)
	);

	assign vis_ok = (tgt_q != org_q) && (32'(tgt_q) < 32'(MAX_LINES)) && !mark;

	// visit accumulation and clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.visit_upd && vis_ok) begin
				cnt_q <= cnt_q + 13'd1;
				sum_q <= sum_q + SW'(dep_q);
			end
			if (cmd.out_load) begin
				cnt_q <= '0;
				sum_q <= '0;
			end
			if (cmd.clr_step) begin
				clr_q <= st.clr_last ? '0 : clr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			org_q <= s_tdata[11:0];
			tgt_q <= s_tdata[23:12];
			dep_q <= s_tdata[24 +: DIN];
		end
	end

	always_comb begin
		n_w = cnt_q + 13'd1;
		x_w = 14'(n_w) + 14'd2;
		k_w = 4'd0;
		for (int j = 1; j <= 11; j++) begin
			if ((14'd3 << j) <= x_w) begin
				k_w = 4'(j);
			end
		end
		den_w = $signed({1'b0, sum_q}) - $signed({1'b0, SW'(cnt_q)});
	end

	assign sq_t = prod_q[61:30];
	assign lm1  = $signed({1'b0, k_q, frac_q}) - 21'sd65536;
	assign nmag = num_q[35] ? QW'(-num_q) : QW'(num_q);
	assign dmag = den_q[DW-1] ? DW'(-den_q) : DW'(den_q);
	assign neg  = num_q[35] ^ den_q[DW-1];
	assign qs   = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});

	isa_div #(.DVD_W(QW), .DVS_W(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (nmag),
		.divisor  (dmag),
		.done     (div_done),
		.quotient (quo)
	);

	// score computation
	always_ff @(posedge clk) begin
		if (cmd.fin_setup) begin
			n_q         <= n_w;
			k_q         <= k_w;
			mant_prod_q <= 47'(x_w) * 47'(isa_pkg::RECIP3);
			den_q       <= den_w;
			frac_q      <= '0;
			if (n_w < 13'd2) begin
				special_q <= 1'b1;
				status_q  <= isa_pkg::ST_TOOFEW;
				score_q   <= 32'hFFFF0000;
			end else if (n_w == 13'd2 || den_w == '0) begin
				special_q <= 1'b1;
				status_q  <= isa_pkg::ST_UNDEF;
				score_q   <= '0;
			end else begin
				special_q <= 1'b0;
				status_q  <= isa_pkg::ST_OK;
				score_q   <= '0;
			end
		end
		// mantissa in q1.30: (n + 2) * 2^(30-k) / 3 by reciprocal multiply
		if (cmd.m_load) begin
			m_q <= 31'(mant_prod_q >> ({1'b0, k_q} + 5'd4));
		end
		if (cmd.sq_mul) begin
			prod_q <= 62'(m_q) * 62'(m_q);
		end
		if (cmd.sq_upd) begin
			frac_q <= {frac_q[14:0], sq_t[31]};
			m_q    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
		end
		if (cmd.num_mul) begin
			prod2_q <= 35'(lm1) * 35'($signed({1'b0, n_q}));
		end
		if (cmd.num_fix) begin
			num_q <= 36'(prod2_q) + 36'sd65536;
		end
		if (cmd.score_set) begin
			if (qs > 35'sd2147483647) begin
				score_q <= 32'h7FFFFFFF;
			end else if (qs < -35'sd2147483648) begin
				score_q <= 32'h80000000;
			end else begin
				score_q <= qs[31:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.out_load) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			on_q  <= n_q;
			otd_q <= 28'(sum_q);
			osc_q <= score_q;
			ost_q <= status_q;
		end
	end

	assign st.clr_last = (clr_q == AW'(MAX_LINES - 1));
	assign st.special  = special_q;
	assign st.div_done = div_done;
	assign st.out_full = ov_q;

	assign m_tvalid = ov_q;
	assign m_tdata  = {7'b0, osc_q, otd_q, on_q};
	assign m_tuser  = ost_q;

endmodule

[src/isa_ctrl.sv]
module isa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic            s_tuser,
	input  isa_pkg::stat_t  st,
	output isa_pkg::cmd_t   cmd
);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_VISIT, S_FIN, S_DECIDE, S_MANT,
		S_SQ_MUL, S_SQ_UPD, S_NMUL, S_NFIX, S_SDIV_GO, S_SDIV_W, S_SCORE, S_LOAD
	} state_t;

	state_t     state_q;
	logic [3:0] sq_cnt_q;
	logic       accept;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd               = '0;
		cmd.capture       = accept;
		cmd.visit_upd     = (state_q == S_VISIT);
		cmd.clr_step      = (state_q == S_CLR);
		cmd.fin_setup     = (state_q == S_FIN);
		cmd.div_start     = (state_q == S_SDIV_GO);
		cmd.m_load        = (state_q == S_MANT);
		cmd.sq_mul        = (state_q == S_SQ_MUL);
		cmd.sq_upd        = (state_q == S_SQ_UPD);
		cmd.num_mul       = (state_q == S_NMUL);
		cmd.num_fix       = (state_q == S_NFIX);
		cmd.score_set     = (state_q == S_SCORE);
		cmd.out_load      = (state_q == S_LOAD) && !st.out_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			sq_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					if (st.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= (s_tuser == isa_pkg::FUNC_FINISH) ? S_FIN : S_VISIT;
					end
				end
				S_VISIT:   state_q <= S_IDLE;
				S_FIN:     state_q <= S_DECIDE;
				S_DECIDE: begin
					sq_cnt_q <= '0;
					state_q  <= st.special ? S_LOAD : S_MANT;
				end
				S_MANT:    state_q <= S_SQ_MUL;
				S_SQ_MUL:  state_q <= S_SQ_UPD;
				S_SQ_UPD: begin
					sq_cnt_q <= sq_cnt_q + 4'd1;
					state_q  <= (sq_cnt_q == 4'd15) ? S_NMUL : S_SQ_MUL;
				end
				S_NMUL:    state_q <= S_NFIX;
				S_NFIX:    state_q <= S_SDIV_GO;
				S_SDIV_GO: state_q <= S_SDIV_W;
				S_SDIV_W: begin
					if (st.div_done) state_q <= S_SCORE;
				end
				S_SCORE:   state_q <= S_LOAD;
				S_LOAD: begin
					if (!st.out_full) state_q <= S_CLR;
				end
				default:   state_q <= S_CLR;
			endcase
		end
	end

endmodule

[src/integration_score_accumulator.sv]
// integration score accumulator, one origin line at a time
// input channel s_*: a request is a visit event (s_tuser = 0) or a finish (s_tuser = 1);
//   visit fields in s_tdata: origin line, target line, depth
// output channel m_*: one result per finish, node count, total depth and the Q16.16 score
//   in m_tdata, status in m_tuser
// a visit reads the visited store on acceptance, then does its write-back in S_VISIT
// a finish shows its result after a reciprocal multiply for the log mantissa, 16 square-and-compare
//   rounds on one 31x31 multiplier, and a 33-step signed divide; too few nodes or an undefined
//   division skip these steps
// after a finish the visited store is cleared, all MAX_LINES lines, before the next request
// reset starts the same clearing pass; s_tready stays low meanwhile
// the result sits in an output register; a stalled receiver only holds back the next
//   finish, visits and the clearing pass go on
module integration_score_accumulator #(
	parameter int MAX_LINES  = 4096,
	parameter int DEPTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // origin_line[11:0], target_line[23:12], depth[39:24]
	input  logic        s_tuser,   // func[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // node_count[12:0], total_depth[40:13], score[72:41]
	output logic [1:0]  m_tuser    // status[1:0]
);

	isa_pkg::cmd_t  cmd;
	isa_pkg::stat_t st;

	isa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.st       (st),
		.cmd      (cmd)
	);

	isa_datapath #(.MAX_LINES(MAX_LINES), .DEPTH_BITS(DEPTH_BITS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.st       (st),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

[src/isa_checker.sv]
module isa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata,
	input logic [1:0]  m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_toofew: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[12:0] < 13'd2) == (m_tuser == isa_pkg::ST_TOOFEW)))
		else $error("too-few status does not match node count");

	a_toofew_score: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == isa_pkg::ST_TOOFEW |-> m_tdata[72:41] == 32'hFFFF0000)
		else $error("too-few result without score of minus one");

	a_undef_score: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == isa_pkg::ST_UNDEF |-> m_tdata[72:41] == 32'h0)
		else $error("undefined result with nonzero score");

	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> !s_tready)
		else $error("request taken right after a finish");

endmodule

bind integration_score_accumulator isa_checker u_chk (.*);

[tb/tb_integration_score_accumulator.sv]
module tb_integration_score_accumulator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINES = 4096;
	localparam longint CYCLE_LIMIT = 10000000;

	typedef struct packed {
		isa_pkg::func_t func;
		logic [11:0]    origin;
		logic [11:0]    target;
		logic [15:0]    depth;
	} visit_req_t;

	typedef struct packed {
		logic [12:0]      node_count;
		logic [27:0]      total_depth;
		logic [31:0]      score;
		isa_pkg::status_t status;
	} score_res_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;

	integration_score_accumulator DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	visit_req_t pending_reqs[$];
	score_res_t expected_scores[$];
	bit         marks[LINES];
	int unsigned n_visited;
	longint     depth_total;
	int         errors = 0;
	bit         hold_sender = 0;
	int         burst_left = 0;
	int         gap_left = 0;
	int         stall_phase = 0;
	longint     cycles = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// log2(x/3) in q16.16, x >= 3
	function automatic longint log2_third(longint x);
		longint k;
		longint m;
		longint frac;
		k = 0;
		frac = 0;
		while (k < 40 && (longint'(3) << (k + 1)) <= x) k++;
		m = (x << 30) / (longint'(3) << k);
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >>> 30;
			frac = frac << 1;
			if (m >= (longint'(2) << 30)) begin
				frac = frac | 1;
				m = m >>> 1;
			end
		end
		return k * isa_pkg::QONE + frac;
	endfunction

	task automatic predict_score(input visit_req_t r);
		score_res_t res;
		longint n;
		longint den;
		longint num;
		longint q;
		if (r.func == isa_pkg::FUNC_VISIT) begin
			if (r.target == r.origin || marks[r.target]) return;
			marks[r.target] = 1;
			depth_total += r.depth;
			n_visited++;
			return;
		end
		n = n_visited + 1;
		res.node_count = n[12:0];
		res.total_depth = depth_total[27:0];
		if (n < 2) begin
			res.score = -isa_pkg::QONE;
			res.status = isa_pkg::ST_TOOFEW;
		end else if (n == 2) begin
			res.score = 0;
			res.status = isa_pkg::ST_UNDEF;
		end else begin
			den = depth_total - (n - 1);
			if (den == 0) begin
				res.score = 0;
				res.status = isa_pkg::ST_UNDEF;
			end else begin
				num = (log2_third(n + 2) - isa_pkg::QONE) * n + isa_pkg::QONE;
				q = num / den;
				if (q > 64'sh7FFFFFFF) q = 64'sh7FFFFFFF;
				if (q < -64'sh80000000) q = -64'sh80000000;
				res.score = q[31:0];
				res.status = isa_pkg::ST_OK;
			end
		end
		expected_scores.push_back(res);
		foreach (marks[i]) marks[i] = 0;
		n_visited = 0;
		depth_total = 0;
	endtask

	// driver: bursts and gaps
	always @(posedge clk or negedge arst_n) begin
		visit_req_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_score(pending_reqs.pop_front());
			end
			if (!(s_tvalid && !s_tready)) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
				if (pending_reqs.size() > 0 && !hold_sender && gap_left == 0) begin
					nxt = pending_reqs[0];
					s_tvalid <= 1'b1;
					s_tdata <= {nxt.depth, nxt.target, nxt.origin};
					s_tuser <= nxt.func;
					burst_left--;
				end else begin
					s_tvalid <= 1'b0;
					if (gap_left > 0) gap_left--;
				end
			end
		end
	end

	// receiver stall pattern and result check
	always @(posedge clk or negedge arst_n) begin
		score_res_t got;
		score_res_t exp_r;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			cycles++;
			if (m_tvalid && m_tready) begin
				got = {m_tdata[12:0], m_tdata[40:13], m_tdata[72:41], m_tuser};
				if (expected_scores.size() == 0) begin
					$error("unexpected result %h", got);
					errors++;
				end else begin
					exp_r = expected_scores.pop_front();
					if (got.node_count !== exp_r.node_count) begin
						$error("node_count exp %0d got %0d", exp_r.node_count, got.node_count);
						errors++;
					end
					if (got.total_depth !== exp_r.total_depth) begin
						$error("total_depth exp %0d got %0d", exp_r.total_depth,
							got.total_depth);
						errors++;
					end
					if (got.score !== exp_r.score) begin
						$error("score exp %h got %h", exp_r.score, got.score);
						errors++;
					end
					if (got.status !== exp_r.status) begin
						$error("status exp %0d got %0d", exp_r.status, got.status);
						errors++;
					end
				end
			end
			stall_phase = (stall_phase + 1) % 64;
			if (stall_phase < 24) m_tready <= 1'b1;
			else m_tready <= ($urandom_range(0, 2) != 0);
		end
	end

	function automatic visit_req_t make_visit(int o, int t, int d);
		visit_req_t r;
		r.func = isa_pkg::FUNC_VISIT;
		r.origin = 12'(o);
		r.target = 12'(t);
		r.depth = 16'(d);
		return r;
	endfunction

	function automatic visit_req_t make_finish();
		visit_req_t r;
		r.func = isa_pkg::FUNC_FINISH;
		r.origin = 12'($urandom);
		r.target = 12'($urandom);
		r.depth = 16'($urandom);
		return r;
	endfunction

	initial begin
		int o;
		int n;
		int dmax;
		int sent;
		arst_n = 0;
		foreach (marks[i]) marks[i] = 0;
		n_visited = 0;
		depth_total = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// directed: too few, two nodes, zero asymmetry, negative denominator, extremes
		pending_reqs.push_back(make_finish());
		pending_reqs.push_back(make_visit(5, 5, 3));
		pending_reqs.push_back(make_finish());
		pending_reqs.push_back(make_visit(0, 4095, 65535));
		pending_reqs.push_back(make_visit(0, 4095, 1));
		pending_reqs.push_back(make_finish());
		pending_reqs.push_back(make_visit(4095, 0, 1));
		pending_reqs.push_back(make_visit(4095, 1, 1));
		pending_reqs.push_back(make_visit(4095, 2, 1));
		pending_reqs.push_back(make_finish());
		pending_reqs.push_back(make_visit(7, 1, 0));
		pending_reqs.push_back(make_visit(7, 2, 0));
		pending_reqs.push_back(make_visit(8, 7, 0));
		pending_reqs.push_back(make_visit(8, 8, 9));
		pending_reqs.push_back(make_finish());
		pending_reqs.push_back(make_visit(1, 2, 65535));
		pending_reqs.push_back(make_visit(1, 3, 65535));
		pending_reqs.push_back(make_visit(1, 2048, 65535));
		pending_reqs.push_back(make_finish());
		sent = 19;

		// pause until everything so far has come back
		wait (pending_reqs.size() == 0);
		hold_sender = 1;
		wait (expected_scores.size() == 0);
		@(posedge clk);
		hold_sender = 0;

		while (sent < 500) begin
			o = $urandom_range(0, 4095);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12);
			dmax = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 8);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 9))
					0: pending_reqs.push_back(make_visit(o, o, $urandom));
					1: pending_reqs.push_back(make_visit($urandom_range(0, 4095),
						$urandom_range(0, 4095), $urandom));
					default: pending_reqs.push_back(make_visit(o,
						$urandom_range(0, 15) == 0 ? $urandom_range(0, 4095)
							: (o + $urandom_range(0, 40)) % LINES,
						$urandom_range(0, dmax)));
				endcase
				sent++;
			end
			pending_reqs.push_back(make_finish());
			sent++;
		end
		wait (pending_reqs.size() == 0 && expected_scores.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_scores.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("FAIL");
		$finish;
	end

endmodule
